// ----- sv/vsbdf_pkg.sv -----
// ----------------------------------------------------------------------------
// vsbdf_pkg: shared types, constants and microcode
// Q16.16 word constants, operation codes and the coefficient/velocity
// micro-programs run by the variable-step BDF coefficient core.
// ----------------------------------------------------------------------------
package vsbdf_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int CNT_BITS  = $clog2(QUO_BITS);
	localparam int PC_BITS   = 6;

	localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic signed [WORD_BITS-1:0] ONE_Q   = WORD_BITS'(1) << FRAC_BITS;
	localparam logic signed [WORD_BITS-1:0] TWO_Q   = WORD_BITS'(2) << FRAC_BITS;
	localparam logic signed [WORD_BITS-1:0] THREE_Q = WORD_BITS'(3) << FRAC_BITS;
	localparam logic signed [WORD_BITS-1:0] FOUR_Q  = WORD_BITS'(4) << FRAC_BITS;
	localparam logic [QUO_BITS-1:0] MAG_MAX =
		{{(QUO_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};

	localparam logic [1:0] KIND_COMPUTE  = 2'd0;
	localparam logic [1:0] KIND_SHIFT    = 2'd1;
	localparam logic [1:0] KIND_RESTART  = 2'd2;
	localparam logic [1:0] KIND_VELOCITY = 2'd3;

	localparam logic [1:0] INT_EULER = 2'd0;
	localparam logic [1:0] INT_CN    = 2'd1;
	localparam logic [1:0] INT_BDF3  = 2'd2;
	localparam logic [1:0] INT_BDF4  = 2'd3;

	localparam logic [1:0] VEL_BACKDIFF = 2'd0;
	localparam logic [1:0] VEL_BDF3     = 2'd1;
	localparam logic [1:0] VEL_ZERO     = 2'd2;
	localparam logic [1:0] VEL_SPARE    = 2'd3;

	localparam logic [1:0] CFG_INTEGRATOR  = 2'd0;
	localparam logic [1:0] CFG_VEL_MODE    = 2'd1;
	localparam logic [1:0] CFG_RST_PREV    = 2'd2;
	localparam logic [1:0] CFG_RST_PREV2   = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic [PC_BITS-1:0] PC_SEL1 = PC_BITS'(0);
	localparam logic [PC_BITS-1:0] PC_SEL2 = PC_BITS'(8);
	localparam logic [PC_BITS-1:0] PC_VEL0 = PC_BITS'(32);
	localparam logic [PC_BITS-1:0] PC_VEL1 = PC_BITS'(34);
	localparam logic [PC_BITS-1:0] PC_END  = PC_BITS'(42);

	typedef enum logic [1:0] {OP_ADD, OP_MUL, OP_DIV} op_t;

	typedef enum logic [4:0] {
		SRC_ZERO, SRC_ONE, SRC_TWO, SRC_THREE, SRC_FOUR,
		SRC_SC, SRC_SP, SRC_SP2, SRC_XN1, SRC_XN, SRC_XM1,
		SRC_C0, SRC_C1, SRC_C2,
		SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4, SRC_R5, SRC_R6, SRC_R7
	} src_t;

	typedef enum logic [3:0] {
		DST_R0, DST_R1, DST_R2, DST_R3, DST_R4, DST_R5, DST_R6, DST_R7,
		DST_C0, DST_C1, DST_C2, DST_C3, DST_VEL
	} dst_t;

	typedef struct packed {
		op_t  op;
		src_t src_a;
		logic neg_a;
		src_t src_b;
		logic neg_b;
		dst_t dst;
		logic last;
	} uop_t;

	typedef struct packed {
		logic                        sat;
		logic signed [WORD_BITS-1:0] val;
	} res_t;

	function automatic uop_t mk(input op_t op, input src_t sa, input logic na,
			input src_t sb, input logic nb, input dst_t d, input logic last);
		uop_t u;
		u.op = op;
		u.src_a = sa;
		u.neg_a = na;
		u.src_b = sb;
		u.neg_b = nb;
		u.dst = d;
		u.last = last;
		return u;
	endfunction

	function automatic uop_t ucode(input logic [PC_BITS-1:0] pc);
		uop_t u;
		case (pc)
			// three-point set
			6'd0:  u = mk(OP_DIV, SRC_SC,   1'b0, SRC_SP,  1'b0, DST_R0, 1'b0);
			6'd1:  u = mk(OP_ADD, SRC_ONE,  1'b0, SRC_R0,  1'b0, DST_R1, 1'b0);
			6'd2:  u = mk(OP_MUL, SRC_TWO,  1'b0, SRC_R0,  1'b0, DST_R2, 1'b0);
			6'd3:  u = mk(OP_ADD, SRC_ONE,  1'b0, SRC_R2,  1'b0, DST_R2, 1'b0);
			6'd4:  u = mk(OP_DIV, SRC_R2,   1'b0, SRC_R1,  1'b0, DST_C0, 1'b0);
			6'd5:  u = mk(OP_ADD, SRC_ONE,  1'b1, SRC_R0,  1'b1, DST_C1, 1'b0);
			6'd6:  u = mk(OP_ADD, SRC_C0,   1'b1, SRC_C1,  1'b1, DST_C2, 1'b0);
			6'd7:  u = mk(OP_ADD, SRC_ZERO, 1'b0, SRC_ZERO, 1'b0, DST_C3, 1'b1);
			// four-point set
			6'd8:  u = mk(OP_DIV, SRC_SC,   1'b0, SRC_SP,  1'b0, DST_R0, 1'b0);
			6'd9:  u = mk(OP_DIV, SRC_SP,   1'b0, SRC_SP2, 1'b0, DST_R1, 1'b0);
			6'd10: u = mk(OP_MUL, SRC_R0,   1'b0, SRC_R1,  1'b0, DST_R2, 1'b0);
			6'd11: u = mk(OP_ADD, SRC_R2,   1'b0, SRC_R1,  1'b0, DST_R3, 1'b0);
			6'd12: u = mk(OP_ADD, SRC_R3,   1'b0, SRC_ONE, 1'b0, DST_R3, 1'b0);
			6'd13: u = mk(OP_ADD, SRC_R0,   1'b0, SRC_ONE, 1'b0, DST_R4, 1'b0);
			6'd14: u = mk(OP_MUL, SRC_R0,   1'b0, SRC_R2,  1'b0, DST_R7, 1'b0);
			6'd15: u = mk(OP_MUL, SRC_THREE, 1'b0, SRC_R7, 1'b0, DST_R5, 1'b0);
			6'd16: u = mk(OP_MUL, SRC_FOUR, 1'b0, SRC_R2,  1'b0, DST_R7, 1'b0);
			6'd17: u = mk(OP_ADD, SRC_R5,   1'b0, SRC_R7,  1'b0, DST_R5, 1'b0);
			6'd18: u = mk(OP_MUL, SRC_TWO,  1'b0, SRC_R0,  1'b0, DST_R7, 1'b0);
			6'd19: u = mk(OP_ADD, SRC_R5,   1'b0, SRC_R7,  1'b0, DST_R5, 1'b0);
			6'd20: u = mk(OP_ADD, SRC_R5,   1'b0, SRC_R1,  1'b0, DST_R5, 1'b0);
			6'd21: u = mk(OP_ADD, SRC_R5,   1'b0, SRC_ONE, 1'b0, DST_R5, 1'b0);
			6'd22: u = mk(OP_MUL, SRC_R4,   1'b0, SRC_R3,  1'b0, DST_R6, 1'b0);
			6'd23: u = mk(OP_DIV, SRC_R5,   1'b0, SRC_R6,  1'b0, DST_C0, 1'b0);
			6'd24: u = mk(OP_ADD, SRC_R1,   1'b0, SRC_ONE, 1'b0, DST_R7, 1'b0);
			6'd25: u = mk(OP_DIV, SRC_R6,   1'b0, SRC_R7,  1'b0, DST_R7, 1'b0);
			6'd26: u = mk(OP_ADD, SRC_R7,   1'b1, SRC_ZERO, 1'b0, DST_C1, 1'b0);
			6'd27: u = mk(OP_MUL, SRC_R0,   1'b0, SRC_R0,  1'b0, DST_R7, 1'b0);
			6'd28: u = mk(OP_MUL, SRC_R7,   1'b0, SRC_R3,  1'b0, DST_R7, 1'b0);
			6'd29: u = mk(OP_DIV, SRC_R7,   1'b0, SRC_R4,  1'b0, DST_C2, 1'b0);
			6'd30: u = mk(OP_ADD, SRC_C0,   1'b1, SRC_C1,  1'b1, DST_R7, 1'b0);
			6'd31: u = mk(OP_ADD, SRC_R7,   1'b0, SRC_C2,  1'b1, DST_C3, 1'b1);
			// backward-difference velocity
			6'd32: u = mk(OP_ADD, SRC_XN1,  1'b0, SRC_XN,  1'b1, DST_R0, 1'b0);
			6'd33: u = mk(OP_DIV, SRC_R0,   1'b0, SRC_SC,  1'b0, DST_VEL, 1'b1);
			// three-point velocity
			6'd34: u = mk(OP_DIV, SRC_C0,   1'b0, SRC_SC,  1'b0, DST_R0, 1'b0);
			6'd35: u = mk(OP_MUL, SRC_R0,   1'b0, SRC_XN1, 1'b0, DST_R0, 1'b0);
			6'd36: u = mk(OP_DIV, SRC_C1,   1'b0, SRC_SC,  1'b0, DST_R1, 1'b0);
			6'd37: u = mk(OP_MUL, SRC_R1,   1'b0, SRC_XN,  1'b0, DST_R1, 1'b0);
			6'd38: u = mk(OP_ADD, SRC_R0,   1'b0, SRC_R1,  1'b0, DST_R0, 1'b0);
			6'd39: u = mk(OP_DIV, SRC_C2,   1'b0, SRC_SC,  1'b0, DST_R1, 1'b0);
			6'd40: u = mk(OP_MUL, SRC_R1,   1'b0, SRC_XM1, 1'b0, DST_R1, 1'b0);
			6'd41: u = mk(OP_ADD, SRC_R0,   1'b0, SRC_R1,  1'b0, DST_VEL, 1'b1);
			default: u = mk(OP_ADD, SRC_ZERO, 1'b0, SRC_ZERO, 1'b0, DST_VEL, 1'b1);
		endcase
		return u;
	endfunction

	function automatic logic [WORD_BITS-1:0] mag(input logic signed [WORD_BITS-1:0] v);
		return v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
	endfunction

	function automatic res_t finish_q(input logic neg, input logic [QUO_BITS-1:0] m);
		res_t r;
		r.sat = 1'b0;
		if (neg) begin
			if (m > MAG_MAX + QUO_BITS'(1)) begin
				r.sat = 1'b1;
				r.val = WMIN;
			end else begin
				r.val = WORD_BITS'(-m);
			end
		end else begin
			if (m > MAG_MAX) begin
				r.sat = 1'b1;
				r.val = WMAX;
			end else begin
				r.val = WORD_BITS'(m);
			end
		end
		return r;
	endfunction

	function automatic res_t add_sat(input logic signed [WORD_BITS-1:0] a, input logic na,
			input logic signed [WORD_BITS-1:0] b, input logic nb);
		logic signed [WORD_BITS+1:0] ea;
		logic signed [WORD_BITS+1:0] eb;
		logic signed [WORD_BITS+1:0] sum;
		res_t r;
		ea = (WORD_BITS+2)'(a);
		eb = (WORD_BITS+2)'(b);
		if (na) ea = -ea;
		if (nb) eb = -eb;
		sum = ea + eb;
		r.sat = 1'b0;
		if (sum > (WORD_BITS+2)'(WMAX)) begin
			r.sat = 1'b1;
			r.val = WMAX;
		end else if (sum < (WORD_BITS+2)'(WMIN)) begin
			r.sat = 1'b1;
			r.val = WMIN;
		end else begin
			r.val = WORD_BITS'(sum);
		end
		return r;
	endfunction

endpackage

// ----- sv/vsbdf_if.sv -----
// ----------------------------------------------------------------------------
// vsbdf_in_if / vsbdf_out_if: item channels
// Valid/ready channels carrying command words in and coefficient words out.
// ----------------------------------------------------------------------------
interface vsbdf_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            kind;
	logic [vsbdf_pkg::WORD_BITS-1:0]        step_new;
	logic                                  have_one_back;
	logic                                  have_two_back;
	logic signed [vsbdf_pkg::WORD_BITS-1:0] pos_next;
	logic signed [vsbdf_pkg::WORD_BITS-1:0] pos_now;
	logic signed [vsbdf_pkg::WORD_BITS-1:0] pos_before;

	modport source (output valid, kind, step_new, have_one_back, have_two_back,
		pos_next, pos_now, pos_before, input ready);
	modport sink (input valid, kind, step_new, have_one_back, have_two_back,
		pos_next, pos_now, pos_before, output ready);
endinterface

interface vsbdf_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [vsbdf_pkg::WORD_BITS-1:0] coef_next;
	logic signed [vsbdf_pkg::WORD_BITS-1:0] coef_now;
	logic signed [vsbdf_pkg::WORD_BITS-1:0] coef_before;
	logic signed [vsbdf_pkg::WORD_BITS-1:0] coef_before2;
	logic signed [vsbdf_pkg::WORD_BITS-1:0] velocity;
	logic [1:0]                            status;

	modport source (output valid, coef_next, coef_now, coef_before, coef_before2,
		velocity, status, input ready);
	modport sink (input valid, coef_next, coef_now, coef_before, coef_before2,
		velocity, status, output ready);
endinterface

// ----- sv/variable_step_bdf_coefficients_core.sv -----
// ----------------------------------------------------------------------------
// variable_step_bdf_coefficients_core: variable-step BDF coefficient unit
// Keeps the step history and four Q16.16 coefficients; computes coefficient
// sets and velocities with one shared add/multiply/divide unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one command word: compute coefficients, shift history,
//          restart reload or velocity. ready is high only while idle.
//   out_ch returns one word per command: the four stored coefficients,
//          the velocity (zero unless a velocity command) and a status code.
//   cfg_we/cfg_index/cfg_data write the integrator, velocity mode and the
//          two restart step sizes; write only while idle.
// Shift, restart, simple sets and zero velocity go straight to the done
//   state; the three- and four-point sets and the two velocity forms
//   step through the microcode. Each division runs in the
//   one-bit-per-cycle restoring divider, each multiply through the product
//   register, each add combinationally; the divider sets the pace.
// The next command is taken as soon as the result sits in the output
//   register; a stalled receiver holds the word and holds the sequencer
//   in its done state until the register frees.
// Reset: steps 1.0, coefficients zero, registers to their defaults.
// ----------------------------------------------------------------------------
module variable_step_bdf_coefficients_core (
	input  logic                            clk,
	input  logic                            arst_n,
	vsbdf_in_if.sink                        in_ch,
	vsbdf_out_if.source                     out_ch,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [vsbdf_pkg::WORD_BITS-1:0] cfg_data
);
	import vsbdf_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_DONE} state_t;

	state_t state_q;
	logic [PC_BITS-1:0] pc_q;
	logic [1:0] integrator_q;
	logic [1:0] vmode_q;
	logic [WORD_BITS-1:0] rst_prev_q, rst_prev2_q;
	logic [WORD_BITS-1:0] step_cur_q, step_prev_q, step_prev2_q;
	logic signed [WORD_BITS-1:0] c0_q, c1_q, c2_q, c3_q, vel_q;
	logic flag_zero_q, flag_sat_q;
	logic out_valid_q;
	logic signed [WORD_BITS-1:0] out_c0_q, out_c1_q, out_c2_q, out_c3_q, out_vel_q;
	logic [1:0] out_status_q;

	logic signed [WORD_BITS-1:0] r0_q, r1_q, r2_q, r3_q, r4_q, r5_q, r6_q, r7_q;
	logic signed [WORD_BITS-1:0] xn1_q, xn_q, xm1_q;
	logic [PROD_BITS-1:0] prod_q;
	logic pneg_q;
	logic [QUO_BITS-1:0] dvd_q, quo_q;
	logic [WORD_BITS-1:0] rem_q, dvs_q;
	logic dneg_q;
	logic [CNT_BITS-1:0] cnt_q;

	uop_t uop;
	logic signed [WORD_BITS-1:0] opa, opb;
	logic [WORD_BITS-1:0] mag_a, mag_b;
	logic step_flag;
	res_t add_r, mul_r, div_r;
	logic [WORD_BITS:0] div_trial;
	logic div_ge;
	logic [WORD_BITS-1:0] rem_n;
	logic [QUO_BITS-1:0] quo_n;
	logic div_last;
	logic wr_en;
	logic signed [WORD_BITS-1:0] wr_val;
	logic set_zero, set_sat;
	logic accept;
	logic out_load;

	function automatic logic signed [WORD_BITS-1:0] src_val(input src_t s);
		logic signed [WORD_BITS-1:0] v;
		case (s)
			SRC_ZERO:  v = '0;
			SRC_ONE:   v = ONE_Q;
			SRC_TWO:   v = TWO_Q;
			SRC_THREE: v = THREE_Q;
			SRC_FOUR:  v = FOUR_Q;
			SRC_SC:    v = step_cur_q[WORD_BITS-1] ? WMAX : signed'(step_cur_q);
			SRC_SP:    v = step_prev_q[WORD_BITS-1] ? WMAX : signed'(step_prev_q);
			SRC_SP2:   v = step_prev2_q[WORD_BITS-1] ? WMAX : signed'(step_prev2_q);
			SRC_XN1:   v = xn1_q;
			SRC_XN:    v = xn_q;
			SRC_XM1:   v = xm1_q;
			SRC_C0:    v = c0_q;
			SRC_C1:    v = c1_q;
			SRC_C2:    v = c2_q;
			SRC_R0:    v = r0_q;
			SRC_R1:    v = r1_q;
			SRC_R2:    v = r2_q;
			SRC_R3:    v = r3_q;
			SRC_R4:    v = r4_q;
			SRC_R5:    v = r5_q;
			SRC_R6:    v = r6_q;
			SRC_R7:    v = r7_q;
			default:   v = '0;
		endcase
		return v;
	endfunction

	function automatic logic step_ovf(input src_t s);
		return (s == SRC_SC && step_cur_q[WORD_BITS-1])
			|| (s == SRC_SP && step_prev_q[WORD_BITS-1])
			|| (s == SRC_SP2 && step_prev2_q[WORD_BITS-1]);
	endfunction

	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	always_comb begin
		uop = ucode(pc_q);
		opa = src_val(uop.src_a);
		opb = src_val(uop.src_b);
		mag_a = mag(opa);
		mag_b = mag(opb);
		step_flag = step_ovf(uop.src_a) || step_ovf(uop.src_b);
		add_r = add_sat(opa, uop.neg_a, opb, uop.neg_b);
		mul_r = finish_q(pneg_q, QUO_BITS'(prod_q >> FRAC_BITS));
		div_trial = {rem_q, dvd_q[QUO_BITS-1]};
		div_ge = div_trial >= {1'b0, dvs_q};
		rem_n = div_ge ? WORD_BITS'(div_trial - {1'b0, dvs_q}) : WORD_BITS'(div_trial);
		quo_n = {quo_q[QUO_BITS-2:0], div_ge};
		div_r = finish_q(dneg_q, quo_n);
		div_last = (cnt_q == CNT_BITS'(QUO_BITS - 1));
		out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);
		wr_en = 1'b0;
		wr_val = add_r.val;
		set_zero = 1'b0;
		set_sat = 1'b0;
		case (state_q)
			S_EXEC: begin
				set_sat = step_flag;
				case (uop.op)
					OP_ADD: begin
						wr_en = 1'b1;
						wr_val = add_r.val;
						set_sat = step_flag || add_r.sat;
					end
					OP_DIV: begin
						if (opb == '0) begin
							wr_en = 1'b1;
							wr_val = opa[WORD_BITS-1] ? WMIN : WMAX;
							set_zero = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_MUL: begin
				wr_en = 1'b1;
				wr_val = mul_r.val;
				set_sat = mul_r.sat;
			end
			S_DIV: begin
				if (div_last) begin
					wr_en = 1'b1;
					wr_val = div_r.val;
					set_sat = div_r.sat;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			integrator_q <= INT_EULER;
			vmode_q <= VEL_BACKDIFF;
			rst_prev_q <= WORD_BITS'(ONE_Q);
			rst_prev2_q <= WORD_BITS'(ONE_Q);
			step_cur_q <= WORD_BITS'(ONE_Q);
			step_prev_q <= WORD_BITS'(ONE_Q);
			step_prev2_q <= WORD_BITS'(ONE_Q);
			c0_q <= '0;
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			vel_q <= '0;
			flag_zero_q <= 1'b0;
			flag_sat_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_c0_q <= '0;
			out_c1_q <= '0;
			out_c2_q <= '0;
			out_c3_q <= '0;
			out_vel_q <= '0;
			out_status_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INTEGRATOR: integrator_q <= cfg_data[1:0];
					CFG_VEL_MODE:   vmode_q <= cfg_data[1:0];
					CFG_RST_PREV:   rst_prev_q <= cfg_data;
					CFG_RST_PREV2:  rst_prev2_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (set_zero) flag_zero_q <= 1'b1;
			if (set_sat) flag_sat_q <= 1'b1;
			if (wr_en) begin
				case (uop.dst)
					DST_C0:  c0_q <= wr_val;
					DST_C1:  c1_q <= wr_val;
					DST_C2:  c2_q <= wr_val;
					DST_C3:  c3_q <= wr_val;
					DST_VEL: vel_q <= wr_val;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						flag_zero_q <= 1'b0;
						flag_sat_q <= (in_ch.kind == KIND_VELOCITY) && step_cur_q[WORD_BITS-1];
						vel_q <= '0;
						case (in_ch.kind)
							KIND_COMPUTE: begin
								step_cur_q <= in_ch.step_new;
								if (integrator_q == INT_EULER || integrator_q == INT_CN
										|| (integrator_q == INT_BDF3 && !in_ch.have_one_back)
										|| (!in_ch.have_one_back && !in_ch.have_two_back)) begin
									c0_q <= ONE_Q;
									c1_q <= -ONE_Q;
									c2_q <= '0;
									c3_q <= '0;
									state_q <= S_DONE;
								end else if (integrator_q == INT_BDF3 || !in_ch.have_two_back) begin
									pc_q <= PC_SEL1;
									state_q <= S_EXEC;
								end else if (in_ch.have_one_back) begin
									pc_q <= PC_SEL2;
									state_q <= S_EXEC;
								end else begin
									state_q <= S_DONE;
								end
							end
							KIND_SHIFT: begin
								step_prev2_q <= step_prev_q;
								step_prev_q <= step_cur_q;
								state_q <= S_DONE;
							end
							KIND_RESTART: begin
								step_cur_q <= rst_prev_q;
								step_prev_q <= rst_prev_q;
								step_prev2_q <= rst_prev2_q;
								state_q <= S_DONE;
							end
							KIND_VELOCITY: begin
								if (vmode_q == VEL_BACKDIFF) begin
									pc_q <= PC_VEL0;
									state_q <= S_EXEC;
								end else if (vmode_q == VEL_BDF3) begin
									pc_q <= PC_VEL1;
									state_q <= S_EXEC;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_EXEC: begin
					if (uop.op == OP_MUL) begin
						state_q <= S_MUL;
					end else if (uop.op == OP_DIV && !wr_en) begin
						state_q <= S_DIV;
					end
				end
				S_MUL, S_DIV: begin
					if (!wr_en) state_q <= state_q;
				end
				S_DONE: begin
					if (out_load) begin
						out_c0_q <= c0_q;
						out_c1_q <= c1_q;
						out_c2_q <= c2_q;
						out_c3_q <= c3_q;
						out_vel_q <= vel_q;
						out_status_q <= flag_zero_q ? ST_ZERO : (flag_sat_q ? ST_SAT : ST_OK);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// advance the sequencer after each completed operation
			if (wr_en && state_q != S_IDLE && state_q != S_DONE) begin
				if (uop.last) begin
					state_q <= S_DONE;
				end else begin
					pc_q <= pc_q + PC_BITS'(1);
					state_q <= S_EXEC;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xn1_q <= in_ch.pos_next;
			xn_q <= in_ch.pos_now;
			xm1_q <= in_ch.pos_before;
		end
		if (state_q == S_EXEC && uop.op == OP_MUL) begin
			prod_q <= PROD_BITS'(mag_a) * PROD_BITS'(mag_b);
			pneg_q <= opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
		end
		if (state_q == S_EXEC && uop.op == OP_DIV) begin
			dvd_q <= {mag_a, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= mag_b;
			dneg_q <= opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
			cnt_q <= '0;
		end
		if (state_q == S_DIV) begin
			dvd_q <= {dvd_q[QUO_BITS-2:0], 1'b0};
			rem_q <= rem_n;
			quo_q <= quo_n;
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
		if (wr_en && state_q != S_IDLE) begin
			case (uop.dst)
				DST_R0: r0_q <= wr_val;
				DST_R1: r1_q <= wr_val;
				DST_R2: r2_q <= wr_val;
				DST_R3: r3_q <= wr_val;
				DST_R4: r4_q <= wr_val;
				DST_R5: r5_q <= wr_val;
				DST_R6: r6_q <= wr_val;
				DST_R7: r7_q <= wr_val;
				default: ;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.coef_next = out_c0_q;
	assign out_ch.coef_now = out_c1_q;
	assign out_ch.coef_before = out_c2_q;
	assign out_ch.coef_before2 = out_c3_q;
	assign out_ch.velocity = out_vel_q;
	assign out_ch.status = out_status_q;

`ifndef NO_ASSERTIONS
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> pc_q < PC_END)
		else $error("sequencer ran past the microcode");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.status != 2'd3)
		else $error("undefined status code");
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted word did not start work");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < dvs_q)
		else $error("divider remainder out of range");
`endif

endmodule
